FILE: hdl/bbag_pkg.sv
// Package for the bouncing arc generator: datapath widths, register indexes,
// sequencer state, multiply step and divide job codes. No dependencies.
package bbag_pkg;

    localparam int CoordW  = 32;   // Q-format coordinate width
    localparam int ProdW   = 51;   // signed product / accumulator width
    localparam int DvdW    = 50;   // unsigned dividend magnitude width
    localparam int DenW    = 18;   // divisor width (steps cubed)
    localparam int CountW  = 6;    // steps and point index width
    localparam int BounceW = 9;    // bounce counter width
    localparam int BcW     = 8;    // bounce_count register width
    localparam int IdxW    = 3;    // configuration index width

    localparam logic [IdxW-1:0] CfgStartX      = 3'd0;
    localparam logic [IdxW-1:0] CfgXMax        = 3'd1;
    localparam logic [IdxW-1:0] CfgYMax        = 3'd2;
    localparam logic [IdxW-1:0] CfgBounceCount = 3'd3;
    localparam logic [IdxW-1:0] CfgSteps       = 3'd4;

    // one quotient bit per cycle over the whole dividend
    localparam logic [5:0] DivLastIter = 6'(DvdW - 1);

    typedef enum logic [2:0] {
        ST_IDLE,   // wait for a request
        ST_MUL,    // shared multiplier evaluates the current step
        ST_WB,     // store the product, pick the next step
        ST_DLD,    // load the divider with a magnitude and rounding bias
        ST_DIV,    // restoring division, one bit per cycle
        ST_DWB,    // sign and store the quotient
        ST_OUT     // present one curve point
    } state_t;

    typedef enum logic [3:0] {
        OP_XN,     // x_max * n
        OP_SS,     // steps * steps
        OP_DEN,    // steps^2 * steps
        OP_YN,     // y_max * (n + 1)
        OP_UU,     // u * u
        OP_W0,     // u^2 * u
        OP_KK,     // k * k
        OP_W3,     // k^2 * k
        OP_UK,     // u * k
        OP_W12,    // u * k * steps (times three on store)
        OP_AX0,    // w0 * start x
        OP_AX1,    // w12 * control x, accumulate
        OP_AX2,    // w3 * end x, accumulate
        OP_PY      // w12 * peak
    } op_t;

    typedef enum logic [1:0] {
        DV_END,    // end x, truncating, by bounce count
        DV_PEAK,   // next peak, truncating, by bounce count
        DV_PX,     // point x, rounding, by steps^3
        DV_PY      // point y, rounding, by steps^3
    } div_kind_t;

endpackage

FILE: hdl/bouncing_bezier_arc_generator.sv
// Bouncing arc generator top level: one request yields steps+1 cubic Bezier points.
// Depends on bbag_pkg. One shared multiplier and one bit-serial divider under a sequencer.
// Sequence: arc setup runs two truncating divisions by bounce count, then each point
// runs ten products and one rounding division each for x and y, then waits at the output
// until the point is taken.
// Requests: one at a time; a new request is taken only while the sequencer is idle.
// Reset (synchronous, active low): control and configuration registers return to defaults, bounce state reloads.
module bouncing_bezier_arc_generator #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bbag_pkg::IdxW-1:0]             cfg_index,
    input  logic [bbag_pkg::CoordW-1:0]           cfg_data,
    // request channel
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_restart,
    // point channel
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [bbag_pkg::CoordW-1:0]    m_point_x,
    output logic signed [bbag_pkg::CoordW-1:0]    m_point_y,
    output logic [bbag_pkg::CountW-1:0]           m_point_index,
    output logic                                  m_last_point,
    output logic                                  m_final_bounce
);

    import bbag_pkg::*;

    // 1.0 in the chosen fixed-point format
    localparam logic signed [CoordW-1:0] OneFixed = CoordW'(1) << FRAC_BITS;
    localparam logic signed [51:0] SatMax = 52'sd2147483647;
    localparam logic signed [51:0] SatMin = -52'sd2147483648;

    function automatic logic signed [CoordW-1:0] sat32(input logic signed [51:0] v);
        if (v > SatMax) begin
            return SatMax[CoordW-1:0];
        end else if (v < SatMin) begin
            return SatMin[CoordW-1:0];
        end
        return v[CoordW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [CoordW-1:0] start_x_reg, x_max_reg, y_max_reg;
    logic [BcW-1:0]           bounce_count_reg;
    logic [CountW-1:0]        steps_reg;

    // ------------------------------------------------------------------
    // Bounce state carried from arc to arc
    // ------------------------------------------------------------------
    logic [BounceW-1:0]       n_reg, n_next;
    logic signed [CoordW-1:0] arc_start_reg, arc_start_next;
    logic signed [CoordW-1:0] peak_reg, peak_next;

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    state_t    state_reg, state_next;
    op_t       op_reg, op_next;
    div_kind_t kind_reg, kind_next;

    logic [BcW-1:0]           bc_reg, bc_next;        // bounce count, zero taken as one
    logic [CountW-1:0]        s_reg, s_next;          // steps, zero taken as one
    logic [CountW-1:0]        k_reg, k_next;
    logic [11:0]              ss_reg, ss_next;
    logic [DenW-1:0]          den_reg, den_next;
    logic [DenW-1:0]          t_reg, t_next;
    logic [DenW-1:0]          w0_reg, w0_next;
    logic [DenW-1:0]          w3_reg, w3_next;
    logic [DenW-1:0]          w12_reg, w12_next;
    logic signed [CoordW-1:0] end_x_reg, end_x_next;
    logic signed [CoordW-1:0] ctrl_x_reg, ctrl_x_next;
    logic signed [CoordW-1:0] peak_nx_reg, peak_nx_next;
    logic signed [ProdW-1:0]  prod_reg, prod_next;
    logic signed [ProdW-1:0]  acc_reg, acc_next;
    logic [DvdW-1:0]          dvd_reg, dvd_next;      // dividend, quotient shifts in
    logic [DenW-1:0]          rem_reg, rem_next;
    logic                     neg_reg, neg_next;
    logic [5:0]               cnt_reg, cnt_next;
    logic signed [CoordW-1:0] px_reg, px_next;
    logic signed [CoordW-1:0] py_reg, py_next;

    // ------------------------------------------------------------------
    // Shared multiplier: 32-bit signed by 19-bit signed
    // ------------------------------------------------------------------
    logic signed [CoordW-1:0] mul_a;
    logic signed [18:0]       mul_b;
    logic [CountW-1:0]        u_val;
    logic [9:0]               n_plus1;

    assign u_val   = s_reg - k_reg;
    assign n_plus1 = {1'b0, n_reg} + 10'd1;

    always_comb begin
        unique case (op_reg)
            OP_XN:   begin mul_a = x_max_reg;             mul_b = {10'b0, n_reg};   end
            OP_SS:   begin mul_a = {26'b0, s_reg};        mul_b = {13'b0, s_reg};   end
            OP_DEN:  begin mul_a = {20'b0, ss_reg};       mul_b = {13'b0, s_reg};   end
            OP_YN:   begin mul_a = y_max_reg;             mul_b = {9'b0, n_plus1};  end
            OP_UU:   begin mul_a = {26'b0, u_val};        mul_b = {13'b0, u_val};   end
            OP_W0:   begin mul_a = {14'b0, t_reg};        mul_b = {13'b0, u_val};   end
            OP_KK:   begin mul_a = {26'b0, k_reg};        mul_b = {13'b0, k_reg};   end
            OP_W3:   begin mul_a = {14'b0, t_reg};        mul_b = {13'b0, k_reg};   end
            OP_UK:   begin mul_a = {26'b0, u_val};        mul_b = {13'b0, k_reg};   end
            OP_W12:  begin mul_a = {14'b0, t_reg};        mul_b = {13'b0, s_reg};   end
            OP_AX0:  begin mul_a = arc_start_reg;         mul_b = {1'b0, w0_reg};   end
            OP_AX1:  begin mul_a = ctrl_x_reg;            mul_b = {1'b0, w12_reg};  end
            OP_AX2:  begin mul_a = end_x_reg;             mul_b = {1'b0, w3_reg};   end
            OP_PY:   begin mul_a = peak_reg;              mul_b = {1'b0, w12_reg};  end
            default: begin mul_a = '0;                    mul_b = '0;               end
        endcase
    end

    // ------------------------------------------------------------------
    // Divider step and helpers
    // ------------------------------------------------------------------
    logic              div_round;
    logic [DenW-1:0]   divisor;
    logic [DenW:0]     rem_sh;
    logic              q_bit;
    logic signed [ProdW-1:0] acc_mag;
    logic signed [ProdW-1:0] quot_s;
    logic signed [51:0]      peak_diff;
    logic signed [33:0]      ctrl_tmp;

    assign div_round = (kind_reg == DV_PX) || (kind_reg == DV_PY);
    assign divisor   = div_round ? den_reg : {10'b0, bc_reg};
    assign rem_sh    = {rem_reg, dvd_reg[DvdW-1]};
    assign q_bit     = (rem_sh >= {1'b0, divisor});
    assign acc_mag   = acc_reg[ProdW-1] ? -acc_reg : acc_reg;
    assign quot_s    = neg_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});
    assign peak_diff = 52'(y_max_reg) - 52'(quot_s);
    // three times end x; quartered toward zero when stored as control x
    assign ctrl_tmp  = 34'(end_x_reg) + (34'(end_x_reg) <<< 1);

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic s_fire, m_fire, last_k;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_OUT);
    assign s_fire    = s_valid && s_ready;
    assign m_fire    = m_valid && m_ready;
    assign last_k    = (k_reg == s_reg);

    // ------------------------------------------------------------------
    // Sequencer: next state and datapath updates
    // ------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        kind_next      = kind_reg;
        n_next         = n_reg;
        arc_start_next = arc_start_reg;
        peak_next      = peak_reg;
        bc_next        = bc_reg;
        s_next         = s_reg;
        k_next         = k_reg;
        ss_next        = ss_reg;
        den_next       = den_reg;
        t_next         = t_reg;
        w0_next        = w0_reg;
        w3_next        = w3_reg;
        w12_next       = w12_reg;
        end_x_next     = end_x_reg;
        ctrl_x_next    = ctrl_x_reg;
        peak_nx_next   = peak_nx_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        px_next        = px_reg;
        py_next        = py_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    // restart: reload the bounce state from the registers
                    if (s_restart) begin
                        n_next         = BounceW'(1);
                        arc_start_next = start_x_reg;
                        peak_next      = y_max_reg;
                    end
                    bc_next    = (bounce_count_reg == '0) ? BcW'(1) : bounce_count_reg;
                    s_next     = (steps_reg == '0) ? CountW'(1) : steps_reg;
                    op_next    = OP_XN;
                    state_next = ST_MUL;
                end
            end

            ST_MUL: begin
                prod_next  = mul_a * mul_b;
                state_next = ST_WB;
            end

            ST_WB: begin
                state_next = ST_MUL;
                unique case (op_reg)
                    OP_XN: begin
                        acc_next   = prod_reg;
                        kind_next  = DV_END;
                        state_next = ST_DLD;
                    end
                    OP_SS: begin
                        ss_next     = prod_reg[11:0];
                        // end x is settled by now
                        ctrl_x_next = ctrl_tmp[33] ? CoordW'((ctrl_tmp + 34'sd3) >>> 2)
                                                   : CoordW'(ctrl_tmp >>> 2);
                        op_next     = OP_DEN;
                    end
                    OP_DEN: begin
                        den_next = prod_reg[DenW-1:0];
                        op_next  = OP_YN;
                    end
                    OP_YN: begin
                        acc_next   = prod_reg;
                        kind_next  = DV_PEAK;
                        state_next = ST_DLD;
                    end
                    OP_UU: begin
                        t_next  = prod_reg[DenW-1:0];
                        op_next = OP_W0;
                    end
                    OP_W0: begin
                        w0_next = prod_reg[DenW-1:0];
                        op_next = OP_KK;
                    end
                    OP_KK: begin
                        t_next  = prod_reg[DenW-1:0];
                        op_next = OP_W3;
                    end
                    OP_W3: begin
                        w3_next = prod_reg[DenW-1:0];
                        op_next = OP_UK;
                    end
                    OP_UK: begin
                        t_next  = prod_reg[DenW-1:0];
                        op_next = OP_W12;
                    end
                    OP_W12: begin
                        // 3*u^2*k + 3*u*k^2 = 3*u*k*steps
                        w12_next = prod_reg[DenW-1:0] + {prod_reg[DenW-2:0], 1'b0};
                        op_next  = OP_AX0;
                    end
                    OP_AX0: begin
                        acc_next = prod_reg;
                        op_next  = OP_AX1;
                    end
                    OP_AX1: begin
                        acc_next = acc_reg + prod_reg;
                        op_next  = OP_AX2;
                    end
                    OP_AX2: begin
                        acc_next   = acc_reg + prod_reg;
                        kind_next  = DV_PX;
                        state_next = ST_DLD;
                    end
                    OP_PY: begin
                        acc_next   = prod_reg;
                        kind_next  = DV_PY;
                        state_next = ST_DLD;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_DLD: begin
                // divide magnitudes; rounding adds half the divisor (halves away from zero)
                neg_next   = acc_reg[ProdW-1];
                dvd_next   = acc_mag[DvdW-1:0]
                             + (div_round ? {{(DvdW-DenW+1){1'b0}}, den_reg[DenW-1:1]}
                                          : {DvdW{1'b0}});
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end

            ST_DIV: begin
                rem_next = q_bit ? DenW'(rem_sh - {1'b0, divisor}) : rem_sh[DenW-1:0];
                dvd_next = {dvd_reg[DvdW-2:0], q_bit};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == DivLastIter) begin
                    state_next = ST_DWB;
                end
            end

            ST_DWB: begin
                state_next = ST_MUL;
                unique case (kind_reg)
                    DV_END: begin
                        end_x_next = sat32(52'(quot_s));
                        op_next    = OP_SS;
                    end
                    DV_PEAK: begin
                        peak_nx_next = sat32(peak_diff);
                        k_next       = '0;
                        op_next      = OP_UU;
                    end
                    DV_PX: begin
                        px_next = quot_s[CoordW-1:0];
                        op_next = OP_PY;
                    end
                    DV_PY: begin
                        py_next    = quot_s[CoordW-1:0];
                        state_next = ST_OUT;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_OUT: begin
                if (m_fire) begin
                    if (last_k) begin
                        // arc done: advance to the next bounce
                        peak_next      = peak_nx_reg;
                        arc_start_next = end_x_reg;
                        n_next         = n_reg + BounceW'(1);
                        state_next     = ST_IDLE;
                    end else begin
                        k_next     = k_reg + CountW'(1);
                        op_next    = OP_UU;
                        state_next = ST_MUL;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control and configuration registers (reset)
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_x_reg      <= '0;
            x_max_reg        <= OneFixed;
            y_max_reg        <= OneFixed;
            bounce_count_reg <= BcW'(1);
            steps_reg        <= CountW'(32);
            n_reg            <= BounceW'(1);
            arc_start_reg    <= '0;
            peak_reg         <= OneFixed;
            state_reg        <= ST_IDLE;
            op_reg           <= OP_XN;
            kind_reg         <= DV_END;
            cnt_reg          <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CfgStartX:      start_x_reg      <= cfg_data;
                    CfgXMax:        x_max_reg        <= cfg_data;
                    CfgYMax:        y_max_reg        <= cfg_data;
                    CfgBounceCount: bounce_count_reg <= cfg_data[BcW-1:0];
                    CfgSteps:       steps_reg        <= cfg_data[CountW-1:0];
                    default: ;      // drop writes to unknown indexes
                endcase
            end
            n_reg         <= n_next;
            arc_start_reg <= arc_start_next;
            peak_reg      <= peak_next;
            state_reg     <= state_next;
            op_reg        <= op_next;
            kind_reg      <= kind_next;
            cnt_reg       <= cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers (no reset)
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        bc_reg      <= bc_next;
        s_reg       <= s_next;
        k_reg       <= k_next;
        ss_reg      <= ss_next;
        den_reg     <= den_next;
        t_reg       <= t_next;
        w0_reg      <= w0_next;
        w3_reg      <= w3_next;
        w12_reg     <= w12_next;
        end_x_reg   <= end_x_next;
        ctrl_x_reg  <= ctrl_x_next;
        peak_nx_reg <= peak_nx_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        neg_reg     <= neg_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
    end

    // ------------------------------------------------------------------
    // Point outputs, held while the point waits
    // ------------------------------------------------------------------
    assign m_point_x      = px_reg;
    assign m_point_y      = py_reg;
    assign m_point_index  = k_reg;
    assign m_last_point   = last_k;
    assign m_final_bounce = (n_reg == {1'b0, bc_reg});

endmodule
